FILE: hdl/aesrnd_pkg.sv
// aesrnd_pkg: shared types, s-box table and gf(2^8) helper for the keyless aes round
// used by aes_round_without_key; no dependencies
package aesrnd_pkg;

    localparam int unsigned NUM_BYTES = 16;
    localparam int unsigned DATA_W    = 128;
    localparam logic [7:0]  RED_POLY  = 8'h1b;

    typedef logic [7:0] t_byte;
    typedef t_byte t_state [NUM_BYTES];

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // multiply by x in gf(2^8)
    function automatic t_byte gf_double(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? RED_POLY : 8'h00);
    endfunction

endpackage

FILE: hdl/aes_round_without_key.sv
// aes_round_without_key: keyless aes-style round (subbytes, shiftrows, mixcolumns)
// on a row-major 16-byte state, three register stages with per-stage handshake
// depends on aesrnd_pkg
//
// stages: subbytes into r_s1, shiftrows into r_s2, mixcolumns into r_s3, which drives the output
// throughput: one state per cycle; each stage holds its item until the next stage frees
// reset: i_rst_n synchronous active low, clears the stage valid bits only
module aes_round_without_key (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // [63:0] state_high, [127:64] state_low
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata    // [63:0] result_high, [127:64] result_low
);

    aesrnd_pkg::t_state r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    aesrnd_pkg::t_state r_d2, n_d2;
    logic r_v1, r_v2, r_v3;
    logic w_ce1, w_ce2, w_ce3;

    // a stage loads when it is empty or its content moves on
    assign w_ce3 = !r_v3 || i_m_axis_tready;
    assign w_ce2 = !r_v2 || w_ce3;
    assign w_ce1 = !r_v1 || w_ce2;
    assign o_s_axis_tready = w_ce1;
    assign o_m_axis_tvalid = r_v3;

    // byte k sits in bits 63-8(k mod 8) of its 64-bit half, upper half at offset 64
    for (genvar k = 0; k < 16; k++) begin : g_byte
        if (k < 8) begin : g_hi
            assign n_s1[k] = aesrnd_pkg::SBOX[i_s_axis_tdata[63-8*k -: 8]];
            assign o_m_axis_tdata[63-8*k -: 8] = r_s3[k];
        end else begin : g_lo
            assign n_s1[k] = aesrnd_pkg::SBOX[i_s_axis_tdata[191-8*k -: 8]];
            assign o_m_axis_tdata[191-8*k -: 8] = r_s3[k];
        end
    end

    // shiftrows: new (r, c) takes old (r, (c + r) mod 4), doubled copy kept for mixcolumns
    for (genvar r = 0; r < 4; r++) begin : g_shift_r
        for (genvar c = 0; c < 4; c++) begin : g_shift_c
            assign n_s2[4*r + c] = r_s1[4*r + ((c + r) % 4)];
            assign n_d2[4*r + c] = aesrnd_pkg::gf_double(r_s1[4*r + ((c + r) % 4)]);
        end
    end

    // mixcolumns with circulant [2 3 1 1]
    for (genvar c = 0; c < 4; c++) begin : g_mix_c
        for (genvar r = 0; r < 4; r++) begin : g_mix_r
            assign n_s3[4*r + c] =
                r_d2[4*r + c]
              ^ r_d2[4*((r+1)%4) + c]
              ^ r_s2[4*((r+1)%4) + c]
              ^ r_s2[4*((r+2)%4) + c]
              ^ r_s2[4*((r+3)%4) + c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ce1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_ce2) begin
                r_v2 <= r_v1;
            end
            if (w_ce3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce1 && i_s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
        if (w_ce2 && r_v1) begin
            r_s2 <= n_s2;
            r_d2 <= n_d2;
        end
        if (w_ce3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

endmodule

FILE: hdl/aesrnd_chk.sv
// aesrnd_chk: port-level checker for aes_round_without_key, bound to the top level
// depends only on the top level's ports
module aesrnd_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata
);

    // a stalled result stays and holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output changed");

    // an empty output stage means the whole pipe can take a transaction
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    // with no downstream stall an accepted transaction reaches the output valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready ##1 i_m_axis_tready)
        |=> o_m_axis_tvalid)
        else $error("result missing after three cycles");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind aes_round_without_key aesrnd_chk u_aesrnd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: test/tb_aes_round_without_key.sv
`timescale 1ns / 1ps
// tb_aes_round_without_key: self-checking stream testbench for the keyless aes round
// predicts every state with its own subbytes/shiftrows/mixcolumns model; depends on aesrnd_pkg
module tb_aes_round_without_key;

    localparam int unsigned RANDOM_STATES = 1600;
    localparam int unsigned MAX_WAIT      = 6;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned MAX_REPORTS   = 10;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // [63:0] state_high, [127:64] state_low
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // [63:0] result_high, [127:64] result_low

    logic [127:0] pending_states [$];
    logic [127:0] expected_rounds [$];

    logic         in_fire;
    logic         out_fire;
    logic         hold_off;
    int unsigned  in_gap;
    int unsigned  out_wait;
    bit           in_burst;
    bit           out_burst;
    int unsigned  accepted_states;
    int unsigned  mismatches;

    aes_round_without_key DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // multiply by x with reduction
    function automatic aesrnd_pkg::t_byte times_x(input aesrnd_pkg::t_byte v);
        aesrnd_pkg::t_byte shifted;
        shifted = v << 1;
        if (v[7]) begin
            shifted = shifted ^ aesrnd_pkg::RED_POLY;
        end
        return shifted;
    endfunction

    // returns {result_low, result_high}
    function automatic logic [127:0] keyless_round(input logic [63:0] st_hi,
                                                   input logic [63:0] st_lo);
        aesrnd_pkg::t_byte sub [16];
        aesrnd_pkg::t_byte rot [16];
        aesrnd_pkg::t_byte mix [16];
        aesrnd_pkg::t_byte col [4];
        aesrnd_pkg::t_byte dbl [4];
        logic [63:0]       res_hi;
        logic [63:0]       res_lo;
        int                k;
        int                r;
        int                c;
        for (k = 0; k < 16; k++) begin
            if (k < 8) begin
                sub[k] = aesrnd_pkg::SBOX[st_hi[63 - 8 * k -: 8]];
            end else begin
                sub[k] = aesrnd_pkg::SBOX[st_lo[63 - 8 * (k - 8) -: 8]];
            end
        end
        // rows are filled first, row r rotates left by r
        for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
                rot[4 * r + c] = sub[4 * r + ((c + r) % 4)];
            end
        end
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                col[r] = rot[4 * r + c];
                dbl[r] = times_x(col[r]);
            end
            for (r = 0; r < 4; r++) begin
                mix[4 * r + c] = dbl[r] ^ dbl[(r + 1) % 4] ^ col[(r + 1) % 4]
                               ^ col[(r + 2) % 4] ^ col[(r + 3) % 4];
            end
        end
        for (k = 0; k < 8; k++) begin
            res_hi[63 - 8 * k -: 8] = mix[k];
            res_lo[63 - 8 * k -: 8] = mix[k + 8];
        end
        return {res_lo, res_hi};
    endfunction

    // directed states first, then random ones
    initial begin
        logic [63:0] hi;
        logic [63:0] lo;
        int          i;
        int          k;
        pending_states.push_back({64'h0, 64'h0});
        pending_states.push_back({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
        pending_states.push_back({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
        pending_states.push_back({64'h8080_8080_8080_8080, 64'h0101_0101_0101_0101});
        pending_states.push_back({64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff});
        pending_states.push_back({64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100});
        // every byte value once over sixteen states
        for (i = 0; i < 16; i++) begin
            for (k = 0; k < 8; k++) begin
                hi[63 - 8 * k -: 8] = 8'(16 * i + k);
                lo[63 - 8 * k -: 8] = 8'(16 * i + k + 8);
            end
            pending_states.push_back({lo, hi});
        end
        for (i = 0; i < RANDOM_STATES; i++) begin
            pending_states.push_back({$urandom, $urandom, $urandom, $urandom});
        end
    end

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        in_fire  = 1'b0;
        out_fire = 1'b0;
        in_gap   = 0;
        out_wait = 0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        accepted_states = 0;
        mismatches = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender
    always @(negedge i_clk) begin
        logic        nxt_valid;
        int unsigned gap;
        if (i_rst_n) begin
            nxt_valid = s_tvalid;
            gap = in_gap;
            if (!s_tvalid || in_fire) begin
                nxt_valid = 1'b0;
                if (in_fire) begin
                    if ($urandom_range(0, 63) == 0) begin
                        in_burst = !in_burst;
                    end
                    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
                end
                if (gap > 0) begin
                    gap = gap - 1;
                end else if (pending_states.size() > 0) begin
                    s_tdata <= pending_states.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
            in_gap <= gap;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        logic        rdy;
        int unsigned w;
        if (i_rst_n) begin
            w = out_wait;
            if (out_fire) begin
                if ($urandom_range(0, 63) == 0) begin
                    out_burst = !out_burst;
                end
                w = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_off) begin
                rdy = 1'b0;
            end else if (w > 0) begin
                rdy = 1'b0;
                w = w - 1;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
            out_wait <= w;
        end
    end

    // long output stall so the pipeline fills and backs up the input
    initial begin
        wait (accepted_states >= 400);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // input transaction: record the expected round
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            expected_rounds.push_back(keyless_round(s_tdata[63:0], s_tdata[127:64]));
            accepted_states <= accepted_states + 1;
        end
    end

    // output transaction: compare with the oldest expected round
    always @(posedge i_clk) begin
        logic [127:0] want;
        out_fire <= i_rst_n && m_tvalid && m_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_rounds.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: result_high=%h result_low=%h",
                             m_tdata[63:0], m_tdata[127:64]);
                end
            end else begin
                want = expected_rounds.pop_front();
                if (m_tdata[63:0] !== want[63:0] || m_tdata[127:64] !== want[127:64]) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: result_high exp %h got %h, result_low exp %h got %h",
                                 want[63:0], m_tdata[63:0], want[127:64], m_tdata[127:64]);
                    end
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        wait (pending_states.size() == 0 && !s_tvalid && expected_rounds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_rounds.size() != 0) begin
            mismatches = mismatches + expected_rounds.size();
            $display("%0d expected results never arrived", expected_rounds.size());
        end
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: aes_round_without_key.f
hdl/aesrnd_pkg.sv
hdl/aes_round_without_key.sv
hdl/aesrnd_chk.sv
test/tb_aes_round_without_key.sv
